[rtl/pfx_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the postfix expression evaluator
// no dependencies; used by the interfaces, the core, the divider and the checker
package pfx_pkg;

   // stack geometry
   localparam int STACK_DEPTH = 16;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // token and result field widths
   localparam int KIND_W = 2;
   localparam int OPC_W  = 3;
   localparam int ERR_W  = 3;
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;

   // divider sizing: dividend is |a| shifted left by the fraction width
   localparam int DIVIDEND_W = DATA_W + FRAC_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // token kinds
   localparam logic [KIND_W-1:0] KIND_NUMBER   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OPERATOR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END      = 2'd2;

   // operator codes
   localparam logic [OPC_W-1:0] OP_ADD = 3'd0;
   localparam logic [OPC_W-1:0] OP_SUB = 3'd1;
   localparam logic [OPC_W-1:0] OP_MUL = 3'd2;
   localparam logic [OPC_W-1:0] OP_DIV = 3'd3;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK       = 3'd0;
   localparam logic [ERR_W-1:0] ERR_MISSING  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_DIVZERO  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_EMPTY    = 3'd4;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd5;

   // core sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_B,
      ST_READ_A,
      ST_MUL_WB,
      ST_DIV,
      ST_END_READ,
      ST_END_OUT
   } state_type;

endpackage

[rtl/pfx_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces for token requests and expression responses
// depends on pfx_pkg for field widths

interface pfx_req_if;
   logic                              valid;
   logic                              ready;
   logic [pfx_pkg::KIND_W-1:0]        kind;
   logic signed [pfx_pkg::DATA_W-1:0] number_value;
   logic [pfx_pkg::OPC_W-1:0]         operator_code;

   modport source (output valid, output kind, output number_value,
                   output operator_code, input ready);
   modport sink   (input valid, input kind, input number_value,
                   input operator_code, output ready);
endinterface

interface pfx_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pfx_pkg::DATA_W-1:0] result_value;
   logic [pfx_pkg::ERR_W-1:0]         error_code;

   modport source (output valid, output result_value, output error_code,
                   input ready);
   modport sink   (input valid, input result_value, input error_code,
                   output ready);
endinterface

[rtl/pfx_ram.sv]
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module pfx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pfx_divider.sv]
`timescale 1ns / 1ps
// unsigned restoring divider, one quotient bit per cycle
// depends on pfx_pkg for operand widths and step count
module pfx_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [pfx_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [pfx_pkg::DATA_W-1:0]         divisor,
   output logic                               done,
   output logic [pfx_pkg::DIVIDEND_W-1:0]     quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [pfx_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [pfx_pkg::DATA_W:0]          rem_ff, rem_in;
   logic [pfx_pkg::DIVIDEND_W-1:0]    quo_ff, quo_in;
   logic [pfx_pkg::DATA_W-1:0]        div_ff, div_in;
   logic [pfx_pkg::DATA_W:0]          rem_shift;
   logic [pfx_pkg::DATA_W:0]          rem_diff;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      // shift in next dividend bit, trial subtract
      rem_shift = {rem_ff[pfx_pkg::DATA_W-1:0], quo_ff[pfx_pkg::DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, div_ff}) begin
            rem_in = rem_diff;
            quo_in = {quo_ff[pfx_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[pfx_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pfx_pkg::DIV_CNT_W'(pfx_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/postfix_expression_evaluator_core.sv]
`timescale 1ns / 1ps
// postfix (rpn) expression evaluator over signed q16.16, stack held in a ram
// depends on pfx_pkg, pfx_if (pfx_req_if, pfx_rsp_if), pfx_ram and pfx_divider
//
//   channel       dir  handshake              payload
//   req_channel   in   valid/ready            kind, number_value, operator_code
//   rsp_channel   out  valid/ready            result_value, error_code
//
// per transaction: number, ignored token or rejected operator handled on accept;
// add/subtract read two stack ram entries, then write back; multiply adds a
// product register; divide uses the divider (one quotient bit per cycle); end
// reads the top entry, plus any wait for the response register to drain.
// reset clears the stack count, the sticky error and the handshake state; the
// stack ram needs no clearing pass, entries at or above the count are never used.
// a pending response holds the block only once the next end transaction is taken,
// tokens ahead of that end keep flowing
module postfix_expression_evaluator_core (
   input  logic          clock,
   input  logic          reset,
   pfx_req_if.sink       req_channel,
   pfx_rsp_if.source     rsp_channel
);

   localparam logic signed [63:0] SAT_MAX    = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_MIN    = -64'sh0000_0000_8000_0000;
   localparam logic signed [63:0] FRAC_ROUND = 64'((64'sd1 <<< pfx_pkg::FRAC_W) - 1);

   // saturate a wide signed value to the 32 bit range
   function automatic logic [pfx_pkg::DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic [pfx_pkg::DATA_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[pfx_pkg::DATA_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[pfx_pkg::DATA_W-1:0];
      end else begin
         r = v[pfx_pkg::DATA_W-1:0];
      end
      return r;
   endfunction

   // magnitude of a signed 32 bit value (int min maps to 2^31)
   function automatic logic [pfx_pkg::DATA_W-1:0] abs32(input logic [pfx_pkg::DATA_W-1:0] v);
      logic [pfx_pkg::DATA_W-1:0] r;
      r = v[pfx_pkg::DATA_W-1] ? (~v + 1'b1) : v;
      return r;
   endfunction

   // sequencer and stack bookkeeping
   pfx_pkg::state_type                state_ff, state_in;
   logic [pfx_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [pfx_pkg::ERR_W-1:0]         err_ff, err_in;
   logic [pfx_pkg::OPC_W-1:0]         op_ff, op_in;
   logic [pfx_pkg::DATA_W-1:0]        b_ff, b_in;
   logic                              neg_ff, neg_in;
   logic signed [63:0]                prod_ff, prod_in;
   logic [pfx_pkg::ERR_W-1:0]         end_err_ff, end_err_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pfx_pkg::DATA_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [pfx_pkg::ERR_W-1:0]         rsp_err_ff, rsp_err_in;

   // stack ram ports
   logic                              ram_wr_en;
   logic [pfx_pkg::IDX_W-1:0]         ram_wr_addr;
   logic [pfx_pkg::DATA_W-1:0]        ram_wr_data;
   logic                              ram_rd_en;
   logic [pfx_pkg::IDX_W-1:0]         ram_rd_addr;
   logic [pfx_pkg::DATA_W-1:0]        ram_rd_data;

   // divider ports
   logic                              div_start;
   logic [pfx_pkg::DIVIDEND_W-1:0]    div_dividend;
   logic [pfx_pkg::DATA_W-1:0]        div_divisor;
   logic                              div_done;
   logic [pfx_pkg::DIVIDEND_W-1:0]    div_quotient;

   // datapath helpers
   logic                              req_accept;
   logic [pfx_pkg::CNT_W-1:0]         count_m1;
   logic [pfx_pkg::CNT_W-1:0]         count_m2;
   logic signed [pfx_pkg::DATA_W:0]   sum_wide;
   logic signed [pfx_pkg::DATA_W:0]   diff_wide;
   logic signed [63:0]                prod_adj;
   logic signed [63:0]                prod_shift;
   logic [pfx_pkg::DIVIDEND_W-1:0]    quo_neg;
   logic [pfx_pkg::DATA_W-1:0]        div_result;

   assign req_accept = req_channel.valid && req_channel.ready;
   assign count_m1   = count_ff - pfx_pkg::CNT_W'(1);
   assign count_m2   = count_ff - pfx_pkg::CNT_W'(2);

   // a sits in the ram read register, b in b_ff; both were loaded in ST_READ_B
   assign sum_wide  = {ram_rd_data[pfx_pkg::DATA_W-1], ram_rd_data}
                    + {b_ff[pfx_pkg::DATA_W-1], b_ff};
   assign diff_wide = {ram_rd_data[pfx_pkg::DATA_W-1], ram_rd_data}
                    - {b_ff[pfx_pkg::DATA_W-1], b_ff};

   // product / 65536 truncating toward zero
   assign prod_adj   = prod_ff + (prod_ff[63] ? FRAC_ROUND : 64'sd0);
   assign prod_shift = prod_adj >>> pfx_pkg::FRAC_W;

   // sign the unsigned quotient and saturate
   assign quo_neg = ~div_quotient + 1'b1;
   always_comb begin
      if (neg_ff) begin
         if (div_quotient > pfx_pkg::DIVIDEND_W'(64'h8000_0000)) begin
            div_result = SAT_MIN[pfx_pkg::DATA_W-1:0];
         end else begin
            div_result = quo_neg[pfx_pkg::DATA_W-1:0];
         end
      end else begin
         if (div_quotient > pfx_pkg::DIVIDEND_W'(64'h7FFF_FFFF)) begin
            div_result = SAT_MAX[pfx_pkg::DATA_W-1:0];
         end else begin
            div_result = div_quotient[pfx_pkg::DATA_W-1:0];
         end
      end
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      op_in        = op_ff;
      b_in         = b_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      end_err_in   = end_err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_m2[pfx_pkg::IDX_W-1:0];
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = count_m1[pfx_pkg::IDX_W-1:0];
      div_start    = 1'b0;
      div_dividend = {abs32(ram_rd_data), {pfx_pkg::FRAC_W{1'b0}}};
      div_divisor  = abs32(b_ff);

      // response leaves when the sink takes it
      if (rsp_valid_ff && rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pfx_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_channel.kind)
                  pfx_pkg::KIND_NUMBER: begin
                     if (err_ff == pfx_pkg::ERR_OK) begin
                        if (count_ff == pfx_pkg::CNT_W'(pfx_pkg::STACK_DEPTH)) begin
                           err_in = pfx_pkg::ERR_OVERFLOW;
                        end else begin
                           // push straight into the ram
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = count_ff[pfx_pkg::IDX_W-1:0];
                           ram_wr_data = req_channel.number_value;
                           count_in    = count_ff + 1'b1;
                        end
                     end
                  end
                  pfx_pkg::KIND_OPERATOR: begin
                     if (err_ff == pfx_pkg::ERR_OK) begin
                        if (count_ff < pfx_pkg::CNT_W'(2)) begin
                           err_in = pfx_pkg::ERR_MISSING;
                        end else if (req_channel.operator_code > pfx_pkg::OP_DIV) begin
                           err_in = pfx_pkg::ERR_UNKNOWN;
                        end else begin
                           // fetch second operand (top of stack)
                           op_in     = req_channel.operator_code;
                           ram_rd_en = 1'b1;
                           state_in  = pfx_pkg::ST_READ_B;
                        end
                     end
                  end
                  pfx_pkg::KIND_END: begin
                     if (err_ff != pfx_pkg::ERR_OK) begin
                        end_err_in = err_ff;
                     end else if (count_ff == '0) begin
                        end_err_in = pfx_pkg::ERR_EMPTY;
                     end else begin
                        end_err_in = pfx_pkg::ERR_OK;
                     end
                     // read top now; discarded on error
                     ram_rd_en = 1'b1;
                     count_in  = '0;
                     err_in    = pfx_pkg::ERR_OK;
                     state_in  = pfx_pkg::ST_END_READ;
                  end
                  default: begin
                     // unused kind is dropped
                  end
               endcase
            end
         end

         pfx_pkg::ST_READ_B: begin
            // b arrives, fetch first operand below it
            b_in        = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = count_m2[pfx_pkg::IDX_W-1:0];
            state_in    = pfx_pkg::ST_READ_A;
         end

         pfx_pkg::ST_READ_A: begin
            case (op_ff)
               pfx_pkg::OP_ADD: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = sat32(64'(sum_wide));
                  count_in    = count_m1;
                  state_in    = pfx_pkg::ST_IDLE;
               end
               pfx_pkg::OP_SUB: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = sat32(64'(diff_wide));
                  count_in    = count_m1;
                  state_in    = pfx_pkg::ST_IDLE;
               end
               pfx_pkg::OP_MUL: begin
                  prod_in  = $signed(ram_rd_data) * $signed(b_ff);
                  state_in = pfx_pkg::ST_MUL_WB;
               end
               pfx_pkg::OP_DIV: begin
                  if (b_ff == '0) begin
                     // stack left as it was
                     err_in   = pfx_pkg::ERR_DIVZERO;
                     state_in = pfx_pkg::ST_IDLE;
                  end else begin
                     div_start = 1'b1;
                     neg_in    = ram_rd_data[pfx_pkg::DATA_W-1] ^ b_ff[pfx_pkg::DATA_W-1];
                     state_in  = pfx_pkg::ST_DIV;
                  end
               end
               default: begin
                  state_in = pfx_pkg::ST_IDLE;
               end
            endcase
         end

         pfx_pkg::ST_MUL_WB: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = sat32(prod_shift);
            count_in    = count_m1;
            state_in    = pfx_pkg::ST_IDLE;
         end

         pfx_pkg::ST_DIV: begin
            if (div_done) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = div_result;
               count_in    = count_m1;
               state_in    = pfx_pkg::ST_IDLE;
            end
         end

         pfx_pkg::ST_END_READ: begin
            // ram read register now holds the top entry and stays put
            state_in = pfx_pkg::ST_END_OUT;
         end

         pfx_pkg::ST_END_OUT: begin
            if (!rsp_valid_ff || rsp_channel.ready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = end_err_ff;
               rsp_value_in = (end_err_ff == pfx_pkg::ERR_OK) ? ram_rd_data : '0;
               state_in     = pfx_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pfx_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfx_pkg::ST_IDLE;
         count_ff     <= '0;
         err_ff       <= pfx_pkg::ERR_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      b_ff         <= b_in;
      neg_ff       <= neg_in;
      prod_ff      <= prod_in;
      end_err_ff   <= end_err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // tokens are taken only between operations
   assign req_channel.ready        = (state_ff == pfx_pkg::ST_IDLE);
   assign rsp_channel.valid        = rsp_valid_ff;
   assign rsp_channel.result_value = rsp_value_ff;
   assign rsp_channel.error_code   = rsp_err_ff;

   pfx_ram #(
      .WIDTH (pfx_pkg::DATA_W),
      .DEPTH (pfx_pkg::STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pfx_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule

[rtl/pfx_checker.sv]
`timescale 1ns / 1ps
// port-level assertions for the postfix expression evaluator, with its bind
// depends on pfx_pkg and postfix_expression_evaluator_core
module pfx_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [pfx_pkg::KIND_W-1:0]   req_kind,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pfx_pkg::DATA_W-1:0]   rsp_result_value,
   input logic [pfx_pkg::ERR_W-1:0]    rsp_error_code
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
                                  && $stable(rsp_error_code))
      else $error("response changed while stalled");

   // error codes stay within the defined set
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= pfx_pkg::ERR_OVERFLOW)
      else $error("response error code out of range");

   // an error response carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != pfx_pkg::ERR_OK |-> rsp_result_value == '0)
      else $error("error response with nonzero value");

   // an end transaction blocks input while the top entry is read
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == pfx_pkg::KIND_END |=> !req_ready)
      else $error("input ready right after end transaction");

   // reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind postfix_expression_evaluator_core pfx_checker u_pfx_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_channel.valid),
   .req_ready        (req_channel.ready),
   .req_kind         (req_channel.kind),
   .rsp_valid        (rsp_channel.valid),
   .rsp_ready        (rsp_channel.ready),
   .rsp_result_value (rsp_channel.result_value),
   .rsp_error_code   (rsp_channel.error_code)
);
